// ===== rtl/bmlt_pkg.sv =====
// ----------------------------------------------------------------------------
// bmlt_pkg
// Shared types and constants of the bookmark list table.
// ----------------------------------------------------------------------------
package bmlt_pkg;

  localparam int MAX_ENTRIES = 16;
  localparam int NUM_BOOKS   = 8;

  localparam int KIND_W  = 2;
  localparam int SLOT_W  = 3;
  localparam int INDEX_W = 4;
  localparam int WORD_W  = 32;
  localparam int ENTRY_W = 3 * WORD_W;
  localparam int LEN_W   = 5;

  localparam int CNT_W       = $clog2(MAX_ENTRIES + 1);
  localparam int CMP_W       = (CNT_W > INDEX_W) ? CNT_W : INDEX_W;
  localparam int BOOK_IDX_W  = (NUM_BOOKS > 1) ? $clog2(NUM_BOOKS) : 1;
  localparam int SLOT_EXT_W  = (SLOT_W > BOOK_IDX_W) ? SLOT_W : BOOK_IDX_W;
  localparam int STORE_DEPTH = NUM_BOOKS * MAX_ENTRIES;
  localparam int ADDR_W      = (STORE_DEPTH > 1) ? $clog2(STORE_DEPTH) : 1;

  localparam int IN_FIELDS_W  = SLOT_W + INDEX_W + ENTRY_W;
  localparam int IN_DATA_W    = ((IN_FIELDS_W + 7) / 8) * 8;
  localparam int OUT_FIELDS_W = LEN_W + ENTRY_W;
  localparam int OUT_DATA_W   = ((OUT_FIELDS_W + 7) / 8) * 8;

  typedef enum logic [KIND_W-1:0] {
    KIND_ADD    = 2'd0,
    KIND_REMOVE = 2'd1,
    KIND_GET    = 2'd2,
    KIND_COUNT  = 2'd3
  } kind_t;

  typedef struct packed {
    kind_t               kind;
    logic [SLOT_W-1:0]   book_slot;
    logic [INDEX_W-1:0]  entry_index;
    logic [WORD_W-1:0]   spine;
    logic [WORD_W-1:0]   block;
    logic [WORD_W-1:0]   offset;
  } req_t;

  typedef struct packed {
    logic               ok;
    logic [LEN_W-1:0]   list_length;
    logic [WORD_W-1:0]  spine;
    logic [WORD_W-1:0]  block;
    logic [WORD_W-1:0]  offset;
  } res_t;

  typedef struct packed {
    logic                we;
    logic [ADDR_W-1:0]   waddr;
    logic [ENTRY_W-1:0]  wdata;
    logic [ADDR_W-1:0]   raddr;
  } mem_req_t;

endpackage

// ===== rtl/bookmark_list_table.sv =====
// ----------------------------------------------------------------------------
// bookmark_list_table
// Per-book dense lists of (spine, block, offset) positions with add, remove,
// get and count operations.
// ----------------------------------------------------------------------------
//  channel  | ports                        | payload
//  ---------+------------------------------+---------------------------------
//  input    | in_tvalid/in_tready          | tuser: kind; tdata: slot, index,
//           |                              |   spine, block, offset
//  result   | out_tvalid/out_tready        | tuser: ok; tdata: list_length,
//           |                              |   spine, block, offset
//
//  One transaction at a time; the entry RAM read port (one entry a cycle) paces
//  each request: count and refused requests skip the RAM, get reads one entry,
//  add reads every entry of the list, remove the entries above its index.
//  Reset clears the counts; the entry RAM needs no clearing.
//  A finished result waits in the output register; a new request may be
//  taken meanwhile and stalls only at its own result.
// ----------------------------------------------------------------------------
module bookmark_list_table (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_tvalid,
  output logic                           in_tready,
  input  logic [bmlt_pkg::KIND_W-1:0]    in_tuser,   // kind
  // book_slot, entry_index, spine_in, block_in, offset_in, zero pad
  input  logic [bmlt_pkg::IN_DATA_W-1:0] in_tdata,
  output logic                           out_tvalid,
  input  logic                           out_tready,
  output logic                           out_tuser,  // ok
  // list_length, spine_out, block_out, offset_out, zero pad
  output logic [bmlt_pkg::OUT_DATA_W-1:0] out_tdata
);
  import bmlt_pkg::*;

  req_t                req;
  res_t                res;
  mem_req_t            mem;
  logic [ENTRY_W-1:0]  mem_rdata;
  logic                res_valid;
  logic                res_ready;

  logic                  out_tvalid_r;
  logic                  out_tuser_r;
  logic [OUT_DATA_W-1:0] out_tdata_r;

  localparam int IDX_LSB = SLOT_W;
  localparam int SP_LSB  = SLOT_W + INDEX_W;
  localparam int BL_LSB  = SP_LSB + WORD_W;
  localparam int OF_LSB  = BL_LSB + WORD_W;

  always_comb begin
    req.kind        = kind_t'(in_tuser);
    req.book_slot   = in_tdata[SLOT_W-1:0];
    req.entry_index = in_tdata[IDX_LSB +: INDEX_W];
    req.spine       = in_tdata[SP_LSB +: WORD_W];
    req.block       = in_tdata[BL_LSB +: WORD_W];
    req.offset      = in_tdata[OF_LSB +: WORD_W];
  end

  bmlt_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .req_valid (in_tvalid),
    .req_ready (in_tready),
    .req       (req),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res       (res),
    .mem       (mem),
    .mem_rdata (mem_rdata)
  );

  bmlt_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (STORE_DEPTH)
  ) u_store (
    .clk   (clk),
    .we    (mem.we),
    .waddr (mem.waddr),
    .wdata (mem.wdata),
    .raddr (mem.raddr),
    .rdata (mem_rdata)
  );

  assign res_ready = !out_tvalid_r || out_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_tvalid_r <= 1'b0;
    end else if (res_ready) begin
      out_tvalid_r <= res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (res_ready && res_valid) begin
      out_tuser_r <= res.ok;
      out_tdata_r <= OUT_DATA_W'({res.offset, res.block, res.spine, res.list_length});
    end
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tuser  = out_tuser_r;
  assign out_tdata  = out_tdata_r;

endmodule

// ===== rtl/bmlt_ram.sv =====
// ----------------------------------------------------------------------------
// bmlt_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module bmlt_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                                      clk,
  input  logic                                      we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                          wdata,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                          rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata_r <= mem_r[raddr];
  end

  assign rdata = rdata_r;

endmodule

// ===== rtl/bmlt_ctrl.sv =====
// ----------------------------------------------------------------------------
// bmlt_ctrl
// Sequencer: walks one list through the entry RAM read port, comparing for
// duplicates, shifting entries down, or fetching one entry; keeps the counts.
// ----------------------------------------------------------------------------
module bmlt_ctrl (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        req_valid,
  output logic                        req_ready,
  input  bmlt_pkg::req_t              req,
  output logic                        res_valid,
  input  logic                        res_ready,
  output bmlt_pkg::res_t              res,
  output bmlt_pkg::mem_req_t          mem,
  input  logic [bmlt_pkg::ENTRY_W-1:0] mem_rdata
);
  import bmlt_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE   = 3'b001,
    S_SCAN   = 3'b010,
    S_FINISH = 3'b100
  } state_t;

  state_t              state_r, state_nxt;
  kind_t               kind_r;
  logic                fail_r, fail_nxt;
  logic                dup_r, dup_nxt;
  logic [ADDR_W-1:0]   base_r;
  logic [BOOK_IDX_W-1:0] book_r;
  logic [CNT_W-1:0]    cnt_r;
  logic [CNT_W-1:0]    ptr_r, ptr_nxt;
  logic [CNT_W-1:0]    end_r, end_nxt;
  logic                pend_r;
  logic [CNT_W-1:0]    pend_ptr_r;
  logic [ENTRY_W-1:0]  key_r;
  logic [ENTRY_W-1:0]  got_r;
  logic [CNT_W-1:0]    counts_r [NUM_BOOKS];

  logic [SLOT_EXT_W-1:0] slot_ext;
  logic [BOOK_IDX_W-1:0] book_idx;
  logic                  slot_ok;
  logic [CNT_W-1:0]      cnt_cur;
  logic                  idx_ok;
  logic                  accept;
  logic                  issue;
  logic                  finish;
  logic                  add_ok;
  logic                  rem_ok;
  logic [CNT_W-1:0]      cnt_new;

  assign slot_ext = SLOT_EXT_W'(req.book_slot);
  assign book_idx = slot_ext[BOOK_IDX_W-1:0];
  assign slot_ok  = (32'(slot_ext) < NUM_BOOKS);
  assign cnt_cur  = slot_ok ? counts_r[book_idx] : '0;
  assign idx_ok   = (CMP_W'(req.entry_index) < CMP_W'(cnt_cur));

  assign req_ready = (state_r == S_IDLE);
  assign accept    = req_valid && req_ready;
  assign issue     = (state_r == S_SCAN) && (ptr_r < end_r);
  assign finish    = (state_r == S_FINISH) && res_ready;
  assign add_ok    = (kind_r == KIND_ADD) && !fail_r && !dup_r;
  assign rem_ok    = (kind_r == KIND_REMOVE) && !fail_r;

  always_comb begin
    cnt_new = cnt_r;
    if (add_ok) begin
      cnt_new = cnt_r + CNT_W'(1);
    end else if (rem_ok) begin
      cnt_new = cnt_r - CNT_W'(1);
    end
  end

  // request decode: decide refusal and the scan window up front
  always_comb begin
    fail_nxt = !slot_ok;
    ptr_nxt  = '0;
    end_nxt  = '0;
    case (req.kind)
      KIND_ADD: begin
        if (32'(cnt_cur) >= MAX_ENTRIES) begin
          fail_nxt = 1'b1;
        end
        end_nxt = cnt_cur;
      end
      KIND_REMOVE: begin
        if (!idx_ok) begin
          fail_nxt = 1'b1;
        end
        ptr_nxt = CNT_W'(req.entry_index) + CNT_W'(1);
        end_nxt = cnt_cur;
      end
      KIND_GET: begin
        if (!idx_ok) begin
          fail_nxt = 1'b1;
        end
        ptr_nxt = CNT_W'(req.entry_index);
        end_nxt = CNT_W'(req.entry_index) + CNT_W'(1);
      end
      default: begin
      end
    endcase
  end

  // the duplicate compare unit, used by add only
  always_comb begin
    dup_nxt = dup_r;
    if (pend_r && (kind_r == KIND_ADD) && (mem_rdata == key_r)) begin
      dup_nxt = 1'b1;
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (accept) begin
          if (fail_nxt || (req.kind == KIND_COUNT)) begin
            state_nxt = S_FINISH;
          end else begin
            state_nxt = S_SCAN;
          end
        end
      end
      S_SCAN: begin
        if (!issue && !pend_r) begin
          state_nxt = S_FINISH;
        end
      end
      S_FINISH: begin
        if (res_ready) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      pend_r  <= 1'b0;
      for (int b = 0; b < NUM_BOOKS; b++) begin
        counts_r[b] <= '0;
      end
    end else begin
      state_r <= state_nxt;
      pend_r  <= issue;
      if (finish && !fail_r) begin
        counts_r[book_r] <= cnt_new;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      kind_r <= req.kind;
      fail_r <= fail_nxt;
      dup_r  <= 1'b0;
      base_r <= ADDR_W'(book_idx) * ADDR_W'(MAX_ENTRIES);
      book_r <= book_idx;
      cnt_r  <= cnt_cur;
      ptr_r  <= ptr_nxt;
      end_r  <= end_nxt;
      key_r  <= {req.offset, req.block, req.spine};
    end else begin
      dup_r <= dup_nxt;
      if (issue) begin
        ptr_r <= ptr_r + CNT_W'(1);
      end
    end
    pend_ptr_r <= ptr_r;
    if (pend_r && (kind_r == KIND_GET)) begin
      got_r <= mem_rdata;
    end
  end

  always_comb begin
    mem.raddr = base_r + ADDR_W'(ptr_r);
    mem.we    = 1'b0;
    mem.waddr = base_r + ADDR_W'(cnt_r);
    mem.wdata = key_r;
    if (pend_r && (kind_r == KIND_REMOVE)) begin
      // entry read last cycle moves down one place
      mem.we    = 1'b1;
      mem.waddr = base_r + ADDR_W'(pend_ptr_r - CNT_W'(1));
      mem.wdata = mem_rdata;
    end else if (finish && add_ok) begin
      mem.we = 1'b1;
    end
  end

  always_comb begin
    res_valid       = (state_r == S_FINISH);
    res.ok          = !fail_r && !((kind_r == KIND_ADD) && dup_r);
    res.list_length = fail_r ? LEN_W'(cnt_r) : LEN_W'(cnt_new);
    res.spine       = '0;
    res.block       = '0;
    res.offset      = '0;
    if ((kind_r == KIND_GET) && !fail_r) begin
      res.spine  = got_r[WORD_W-1:0];
      res.block  = got_r[2*WORD_W-1:WORD_W];
      res.offset = got_r[3*WORD_W-1:2*WORD_W];
    end
  end

endmodule

// ===== rtl/bmlt_checker.sv =====
// ----------------------------------------------------------------------------
// bmlt_checker
// Port-level checks of the bookmark list table, bound to the top level.
// ----------------------------------------------------------------------------
module bmlt_checker (
  input logic                            clk,
  input logic                            rst_n,
  input logic                            in_tvalid,
  input logic                            in_tready,
  input logic [bmlt_pkg::KIND_W-1:0]     in_tuser,
  input logic [bmlt_pkg::IN_DATA_W-1:0]  in_tdata,
  input logic                            out_tvalid,
  input logic                            out_tready,
  input logic                            out_tuser,
  input logic [bmlt_pkg::OUT_DATA_W-1:0] out_tdata
);
  import bmlt_pkg::*;

  // stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tuser))
    else $error("result changed while stalled");

  // refused requests return no entry data
  a_refused_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tuser |-> out_tdata[OUT_DATA_W-1:LEN_W] == '0)
    else $error("refused result carries entry data");

  a_len_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> 32'(out_tdata[LEN_W-1:0]) <= MAX_ENTRIES)
    else $error("list length above capacity");

  // one request in flight: not ready right after a transaction
  a_one_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("second request taken while busy");

  a_reset_idle: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("result valid after reset");

endmodule

bind bookmark_list_table bmlt_checker u_bmlt_checker (.*);
